>>> src/salc_pkg.sv
// Shared types, constants and helper functions of the set-associative LRU cache lookup.
package salc_pkg;

    localparam int ADDR_WIDTH = 32;
    localparam int CNT_WIDTH  = 32;
    localparam int CFG_WIDTH  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_SETS   = 1024;
    localparam int SET_BITS   = $clog2(MAX_SETS);
    localparam int MAX_WAYS   = 8;
    localparam int WAY_BITS   = 3;
    localparam int TAG_WIDTH  = 30;
    localparam int SHIFT_W    = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // Register reset values.
    localparam logic [CFG_WIDTH-1:0] INDEX_BITS_RST  = 4'd10;
    localparam logic [CFG_WIDTH-1:0] OFFSET_BITS_RST = 4'd2;
    localparam logic [CFG_WIDTH-1:0] WAYS_RST        = 4'd1;

    // One RAM row holds a whole set: valid bits, tags and the LRU list.
    typedef struct packed {
        logic [MAX_WAYS-1:0]                valid;
        logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] tag;
        logic [MAX_WAYS-1:0][WAY_BITS-1:0]  lru;
    } t_row;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic lookup;
        logic update;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } t_status;

    // Clamp a 4-bit register into [lo, hi].
    function automatic logic [CFG_WIDTH-1:0] clamp4(
        input logic [CFG_WIDTH-1:0] v,
        input logic [CFG_WIDTH-1:0] lo,
        input logic [CFG_WIDTH-1:0] hi
    );
        logic [CFG_WIDTH-1:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // Row value after reset: nothing valid, tags zero, LRU list in way order.
    function automatic t_row reset_row();
        t_row r;
        r.valid = '0;
        r.tag   = '0;
        for (int p = 0; p < MAX_WAYS; p++) begin
            r.lru[p] = WAY_BITS'(p);
        end
        return r;
    endfunction

    // Saturating counter increment.
    function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] v);
        return (v == {CNT_WIDTH{1'b1}}) ? v : v + CNT_WIDTH'(1);
    endfunction

endpackage

>>> src/salc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/salc_ctrl.sv
// Controller state machine: clearing pass, idle, and the lookup and update sequence.
module salc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  salc_pkg::t_status i_status,
    output salc_pkg::t_cmd    o_cmd,
    output logic              busy
);

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.lookup = 1'b1;
                    n_state      = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> src/salc_dp.sv
// Datapath: configuration registers, set RAM, tag compare, LRU update and counters.
module salc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  salc_pkg::t_cmd                      i_cmd,
    output salc_pkg::t_status                   o_status,
    input  logic                                i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [salc_pkg::CFG_WIDTH-1:0]      i_cfg_data,
    input  logic [salc_pkg::ADDR_WIDTH-1:0]     i_address,
    output logic                                o_result_valid,
    output logic                                o_hit,
    output logic [salc_pkg::WAY_BITS-1:0]       o_way,
    output logic [salc_pkg::SET_BITS-1:0]       o_set_index,
    output logic [salc_pkg::CNT_WIDTH-1:0]      o_access_count,
    output logic [salc_pkg::CNT_WIDTH-1:0]      o_hit_count,
    output logic [salc_pkg::CNT_WIDTH-1:0]      o_miss_count
);

    logic [salc_pkg::CFG_WIDTH-1:0]  r_index_bits;
    logic [salc_pkg::CFG_WIDTH-1:0]  r_offset_bits;
    logic [salc_pkg::CFG_WIDTH-1:0]  r_ways;
    logic [salc_pkg::SET_BITS-1:0]   r_clr_addr;
    logic [salc_pkg::ADDR_WIDTH-1:0] r_addr;
    logic [salc_pkg::SET_BITS-1:0]   r_set;
    logic                            r_res_valid;
    logic                            r_hit;
    logic [salc_pkg::WAY_BITS-1:0]   r_way;
    logic [salc_pkg::SET_BITS-1:0]   r_res_set;
    logic [salc_pkg::CNT_WIDTH-1:0]  r_accesses;
    logic [salc_pkg::CNT_WIDTH-1:0]  r_hits;
    logic [salc_pkg::CNT_WIDTH-1:0]  r_misses;

    logic [salc_pkg::CFG_WIDTH-1:0]  ib;
    logic [salc_pkg::CFG_WIDTH-1:0]  ob;
    logic [salc_pkg::CFG_WIDTH-1:0]  w;
    logic [salc_pkg::WAY_BITS-1:0]   w_last;
    logic [salc_pkg::SET_BITS-1:0]   set_mask;
    logic [salc_pkg::SET_BITS-1:0]   in_set;
    logic [salc_pkg::SHIFT_W-1:0]    tag_shift;
    logic [salc_pkg::TAG_WIDTH-1:0]  tag;
    salc_pkg::t_row                  rd_row;
    salc_pkg::t_row                  upd_row;
    salc_pkg::t_row                  wr_row;
    logic [salc_pkg::SET_BITS-1:0]   wr_addr;
    logic                            hit;
    logic [salc_pkg::WAY_BITS-1:0]   way;
    logic [salc_pkg::WAY_BITS-1:0]   pos;
    logic                            found;

    // Configuration registers, raw 4-bit values; clamped where used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits  <= salc_pkg::INDEX_BITS_RST;
            r_offset_bits <= salc_pkg::OFFSET_BITS_RST;
            r_ways        <= salc_pkg::WAYS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                salc_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data;
                salc_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                salc_pkg::CFG_WAYS_IN_USE: r_ways        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ib     = salc_pkg::clamp4(r_index_bits, 4'd1, 4'd10);
    assign ob     = salc_pkg::clamp4(r_offset_bits, 4'd2, 4'd8);
    assign w      = salc_pkg::clamp4(r_ways, 4'd1, 4'(salc_pkg::MAX_WAYS));
    assign w_last = salc_pkg::WAY_BITS'(w - 4'd1);

    // Set index of the incoming address.
    assign set_mask = ~({salc_pkg::SET_BITS{1'b1}} << ib);
    assign in_set   = salc_pkg::SET_BITS'(i_address >> ob) & set_mask;

    // Tag of the captured address.
    assign tag_shift = salc_pkg::SHIFT_W'(ob) + salc_pkg::SHIFT_W'(ib);
    assign tag       = salc_pkg::TAG_WIDTH'(r_addr >> tag_shift);

    // Clearing pass address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + salc_pkg::SET_BITS'(1);
        end
    end

    assign o_status.clear_last = (r_clr_addr == {salc_pkg::SET_BITS{1'b1}});

    // Captured access.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_addr <= i_address;
            r_set  <= in_set;
        end
    end

    // Tag compare over the ways in use; the lowest matching way wins.
    always_comb begin
        hit = 1'b0;
        way = '0;
        for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
            if (!hit && (i < int'(w)) && rd_row.valid[i] && (rd_row.tag[i] == tag)) begin
                hit = 1'b1;
                way = salc_pkg::WAY_BITS'(i);
            end
        end
        if (!hit) begin
            way = rd_row.lru[0];
        end
    end

    // Position of the way in the LRU list; a miss always takes the front.
    always_comb begin
        found = 1'b0;
        pos   = w_last;
        if (hit) begin
            for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
                if (!found && (i < int'(w)) && (rd_row.lru[i] == way)) begin
                    found = 1'b1;
                    pos   = salc_pkg::WAY_BITS'(i);
                end
            end
        end else begin
            pos = '0;
        end
    end

    // Updated row: shift the list down past the position, put the way last; a miss also writes the tag and sets valid.
    always_comb begin
        upd_row = rd_row;
        for (int j = 0; j < salc_pkg::MAX_WAYS - 1; j++) begin
            if ((j >= int'(pos)) && (j < int'(w_last))) begin
                upd_row.lru[j] = rd_row.lru[j + 1];
            end
        end
        upd_row.lru[w_last] = way;
        if (!hit) begin
            upd_row.tag[way]   = tag;
            upd_row.valid[way] = 1'b1;
        end
    end

    // RAM write selection between the clearing pass and the update.
    assign wr_row  = i_cmd.clear ? salc_pkg::reset_row() : upd_row;
    assign wr_addr = i_cmd.clear ? r_clr_addr : r_set;

    salc_ram #(
        .WIDTH ($bits(salc_pkg::t_row)),
        .DEPTH (salc_pkg::MAX_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clear | i_cmd.update),
        .i_waddr (wr_addr),
        .i_wdata (wr_row),
        .i_re    (i_cmd.lookup),
        .i_raddr (in_set),
        .o_rdata (rd_row)
    );

    // Result strobe and statistics counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_accesses  <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
        end else begin
            r_res_valid <= i_cmd.update;
            if (i_cmd.update) begin
                r_accesses <= salc_pkg::sat_inc(r_accesses);
                if (hit) begin
                    r_hits <= salc_pkg::sat_inc(r_hits);
                end else begin
                    r_misses <= salc_pkg::sat_inc(r_misses);
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_hit     <= hit;
            r_way     <= way;
            r_res_set <= r_set;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_hit          = r_hit;
    assign o_way          = r_way;
    assign o_set_index    = r_res_set;
    assign o_access_count = r_accesses;
    assign o_hit_count    = r_hits;
    assign o_miss_count   = r_misses;

endmodule

>>> src/set_assoc_lru_cache_lookup.sv
// The edge that takes an address reads the set row into the RAM output register and moves
// the controller to its update state, which writes the updated row back with busy high and
// registers the result; the result strobe then rises as busy drops again. A new address is
// taken only once busy is low, after the write-back of the last one.
// Reset: synchronous, active low; afterwards a clearing pass writes every set row to its reset
// value with busy high. Configuration is taken at any time.
// The receiver cannot stall: each result strobe is high for exactly one cycle.
module set_assoc_lru_cache_lookup (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [salc_pkg::ADDR_WIDTH-1:0]     i_address,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [salc_pkg::CFG_WIDTH-1:0]      i_cfg_data,
    output logic                                o_result_valid,
    output logic                                o_hit,
    output logic [salc_pkg::WAY_BITS-1:0]       o_way,
    output logic [salc_pkg::SET_BITS-1:0]       o_set_index,
    output logic [salc_pkg::CNT_WIDTH-1:0]      o_access_count,
    output logic [salc_pkg::CNT_WIDTH-1:0]      o_hit_count,
    output logic [salc_pkg::CNT_WIDTH-1:0]      o_miss_count
);

    salc_pkg::t_cmd    cmd;
    salc_pkg::t_status status;

    // Configuration beats are always taken.
    assign o_cfg_ready = 1'b1;

    salc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    salc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_address      (i_address),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .o_way          (o_way),
        .o_set_index    (o_set_index),
        .o_access_count (o_access_count),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count)
    );

    // An accepted address keeps the block busy for its write-back cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && cmd.update))
        else $error("accepted address did not enter the update cycle");

    // Every update produces exactly one result strobe in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |=> (o_result_valid && !busy))
        else $error("update without a following result strobe");

    // A result strobe only follows an update.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(cmd.update))
        else $error("result strobe without an update");

    // The controller never issues two commands at once.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear, cmd.lookup, cmd.update}))
        else $error("conflicting datapath commands");

endmodule

>>> tb/set_assoc_lru_cache_lookup_checker.sv
// Checker for the set-associative LRU cache lookup: tracks the tag store and scores results.
module set_assoc_lru_cache_lookup_checker
    import salc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [ADDR_WIDTH-1:0] i_address,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_WIDTH-1:0]  i_cfg_data,
    input  logic                  i_result_valid,
    input  logic                  i_hit,
    input  logic [WAY_BITS-1:0]   i_way,
    input  logic [SET_BITS-1:0]   i_set_index,
    input  logic [CNT_WIDTH-1:0]  i_access_count,
    input  logic [CNT_WIDTH-1:0]  i_hit_count,
    input  logic [CNT_WIDTH-1:0]  i_miss_count,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // One lookup outcome as the block reports it.
    typedef struct packed {
        logic                 hit;
        logic [WAY_BITS-1:0]  way;
        logic [SET_BITS-1:0]  set_index;
        logic [CNT_WIDTH-1:0] access_count;
        logic [CNT_WIDTH-1:0] hit_count;
        logic [CNT_WIDTH-1:0] miss_count;
    } t_lookup;

    // Shadow copy of the tag store, recency lists and counters.
    logic                 way_valid  [MAX_SETS][MAX_WAYS];
    logic [TAG_WIDTH-1:0] way_tag    [MAX_SETS][MAX_WAYS];
    logic [WAY_BITS-1:0]  recency    [MAX_SETS][MAX_WAYS];
    logic [CNT_WIDTH-1:0] shadow_access;
    logic [CNT_WIDTH-1:0] shadow_hit;
    logic [CNT_WIDTH-1:0] shadow_miss;

    // Shadow copy of the geometry registers, clamped at use.
    logic [CFG_WIDTH-1:0] index_bits_reg;
    logic [CFG_WIDTH-1:0] offset_bits_reg;
    logic [CFG_WIDTH-1:0] ways_reg;

    t_lookup lookups_due[$];
    int      mismatches = 0;

    // Look one address up in the shadow store and apply the LRU update.
    function automatic t_lookup lookup_and_update(input logic [ADDR_WIDTH-1:0] addr);
        int                   ib;
        int                   ob;
        int                   nw;
        int                   set;
        int                   pos;
        logic                 found;
        logic [31:0]          set_idx;
        logic [TAG_WIDTH-1:0] tag;
        logic [WAY_BITS-1:0]  way;
        logic                 hit;
        t_lookup              r;
        ib = (index_bits_reg < 1) ? 1 : (index_bits_reg > 10) ? 10 : int'(index_bits_reg);
        ob = (offset_bits_reg < 2) ? 2 : (offset_bits_reg > 8) ? 8 : int'(offset_bits_reg);
        nw = (ways_reg < 1) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : int'(ways_reg);
        set_idx = (addr >> ob) & ((32'd1 << ib) - 32'd1);
        set     = int'(set_idx % MAX_SETS);
        tag     = TAG_WIDTH'(addr >> (ob + ib));

        // The lowest numbered valid way with a matching tag wins.
        hit = 1'b0;
        way = '0;
        for (int i = 0; i < nw; i++) begin
            if (!hit && way_valid[set][i] && way_tag[set][i] == tag) begin
                hit = 1'b1;
                way = WAY_BITS'(i);
            end
        end

        if (shadow_access != '1) shadow_access++;
        if (hit) begin
            // A hit way missing from the list lands in the newest slot unshifted.
            if (shadow_hit != '1) shadow_hit++;
            pos   = nw - 1;
            found = 1'b0;
            for (int i = 0; i < nw; i++) begin
                if (!found && recency[set][i] == way) begin
                    pos   = i;
                    found = 1'b1;
                end
            end
        end else begin
            // Misses refill whatever way the oldest slot names.
            if (shadow_miss != '1) shadow_miss++;
            way                 = recency[set][0];
            way_tag[set][way]   = tag;
            way_valid[set][way] = 1'b1;
            pos                 = 0;
        end
        for (int i = pos + 1; i < nw; i++) begin
            recency[set][i-1] = recency[set][i];
        end
        recency[set][nw-1] = way;

        r.hit          = hit;
        r.way          = way;
        r.set_index    = SET_BITS'(set_idx);
        r.access_count = shadow_access;
        r.hit_count    = shadow_hit;
        r.miss_count   = shadow_miss;
        return r;
    endfunction

    // Score one field of a result.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
            end
        end
    endtask

    // Per edge: register writes, then result beats, then newly accepted addresses.
    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_SETS; s++) begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    way_valid[s][w] = 1'b0;
                    way_tag[s][w]   = '0;
                    recency[s][w]   = WAY_BITS'(w);
                end
            end
            shadow_access   = '0;
            shadow_hit      = '0;
            shadow_miss     = '0;
            index_bits_reg  = INDEX_BITS_RST;
            offset_bits_reg = OFFSET_BITS_RST;
            ways_reg        = WAYS_RST;
            lookups_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INDEX_BITS: begin
                        index_bits_reg = i_cfg_data;
                    end
                    CFG_OFFSET_BITS: begin
                        offset_bits_reg = i_cfg_data;
                    end
                    CFG_WAYS_IN_USE: begin
                        ways_reg = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_result_valid) begin
                if (lookups_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] result beat with no lookup outstanding", $realtime);
                    end
                end else begin
                    want = lookups_due.pop_front();
                    check_field("hit", 32'(want.hit), 32'(i_hit));
                    check_field("way", 32'(want.way), 32'(i_way));
                    check_field("set_index", 32'(want.set_index), 32'(i_set_index));
                    check_field("access_count", want.access_count, i_access_count);
                    check_field("hit_count", want.hit_count, i_hit_count);
                    check_field("miss_count", want.miss_count, i_miss_count);
                end
            end

            if (i_start && !i_busy) begin
                lookups_due.push_back(lookup_and_update(i_address));
            end
        end
        o_pending    <= lookups_due.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/set_assoc_lru_cache_lookup_tb.sv
// Testbench top for the set-associative LRU cache lookup: stimulus, watchdog and verdict.
module set_assoc_lru_cache_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import salc_pkg::*;

    localparam int RANDOM_PHASES   = 13;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TAG_POOL_SIZE   = MAX_WAYS + 2;
    localparam int SET_POOL_SIZE   = 4;

    // Register index that decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [ADDR_WIDTH-1:0] i_address   = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_INDEX_BITS;
    logic [CFG_WIDTH-1:0]  i_cfg_data  = '0;
    logic                  o_result_valid;
    logic                  o_hit;
    logic [WAY_BITS-1:0]   o_way;
    logic [SET_BITS-1:0]   o_set_index;
    logic [CNT_WIDTH-1:0]  o_access_count;
    logic [CNT_WIDTH-1:0]  o_hit_count;
    logic [CNT_WIDTH-1:0]  o_miss_count;
    int                    fail_count;
    int                    pending;

    // Clamped geometry in force, used to aim addresses at a few sets and tags.
    int                    geo_ib   = 10;
    int                    geo_ob   = 2;
    int                    geo_ways = 1;
    logic [31:0]           tag_pool [TAG_POOL_SIZE];
    logic [31:0]           set_pool [SET_POOL_SIZE];

    always #10 i_clk = ~i_clk;

    set_assoc_lru_cache_lookup dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_address      (i_address),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .o_way          (o_way),
        .o_set_index    (o_set_index),
        .o_access_count (o_access_count),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count)
    );

    set_assoc_lru_cache_lookup_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_address      (i_address),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_result_valid (o_result_valid),
        .i_hit          (o_hit),
        .i_way          (o_way),
        .i_set_index    (o_set_index),
        .i_access_count (o_access_count),
        .i_hit_count    (o_hit_count),
        .i_miss_count   (o_miss_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic int clamp_cfg(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Mostly in range, with extremes and out-of-range codes drawn often.
    function automatic logic [CFG_WIDTH-1:0] pick_reg(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return CFG_WIDTH'(lo);
        end else if (r < 40) begin
            return CFG_WIDTH'(hi);
        end else if (r < 50) begin
            if ($urandom_range(0, 1) == 0) begin
                return CFG_WIDTH'($urandom_range(0, lo - 1));
            end
            return CFG_WIDTH'($urandom_range(hi + 1, 15));
        end
        return CFG_WIDTH'($urandom_range(lo, hi));
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Addresses built from a small pool of tags and sets so that lines get reused.
    function automatic logic [31:0] shaped_address();
        logic [31:0] t;
        logic [31:0] s;
        if ($urandom_range(0, 99) < 15) begin
            return $urandom;
        end
        t = tag_pool[$urandom_range(0, geo_ways + 1)];
        s = set_pool[$urandom_range(0, SET_POOL_SIZE - 1)];
        return (t << (geo_ob + geo_ib)) | (s << geo_ob) |
               ($urandom & ((32'd1 << geo_ob) - 32'd1));
    endfunction

    // Hold one register write beat until it is taken; the caller drops valid.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    // Write all three geometry registers and note the clamped values.
    task automatic set_geometry(input logic [CFG_WIDTH-1:0] ib, input logic [CFG_WIDTH-1:0] ob,
                                input logic [CFG_WIDTH-1:0] nw);
        cfg_write(CFG_INDEX_BITS, ib);
        cfg_write(CFG_OFFSET_BITS, ob);
        cfg_write(CFG_WAYS_IN_USE, nw);
        i_cfg_valid <= 1'b0;
        geo_ib   = clamp_cfg(int'(ib), 1, 10);
        geo_ob   = clamp_cfg(int'(ob), 2, 8);
        geo_ways = clamp_cfg(int'(nw), 1, MAX_WAYS);
    endtask

    // Stop sending and let every outstanding lookup return.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Present one address beat, wait until it is taken, then idle for gap cycles.
    task automatic send_lookup(input logic [31:0] addr, input int gap);
        start     <= 1'b1;
        i_address <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Ends the run if nothing moves on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_result_valid === 1'b1 || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic calm;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry, one way: address extremes, rehits and a conflict eviction.
        send_lookup(32'h0000_0000, draw_gap());
        send_lookup(32'h0000_0000, draw_gap());
        send_lookup(32'hFFFF_FFFF, draw_gap());
        send_lookup(32'hFFFF_FFFF, draw_gap());
        send_lookup(32'h5555_5555, draw_gap());
        send_lookup(32'hAAAA_AAAA, draw_gap());
        send_lookup(32'h0000_1000, draw_gap());
        send_lookup(32'h0000_0000, draw_gap());
        wait_drained();

        // Out-of-range geometry codes clamp to one index bit and eight offset bits.
        cfg_write(CFG_UNUSED, 4'hF);
        set_geometry(4'd0, 4'd15, 4'd4);
        // Fill four ways of set 0, rehit one, evict the oldest twice, then miss in set 1.
        send_lookup(32'h0000_0200, draw_gap());
        send_lookup(32'h0000_0400, draw_gap());
        send_lookup(32'h0000_06FF, draw_gap());
        send_lookup(32'h0000_0800, draw_gap());
        send_lookup(32'h0000_0400, draw_gap());
        send_lookup(32'h0000_0A00, draw_gap());
        send_lookup(32'h0000_0200, draw_gap());
        send_lookup(32'h0000_0300, draw_gap());
        wait_drained();

        // Shrink to two ways with the other ways still holding lines.
        set_geometry(4'd1, 4'd8, 4'd2);
        send_lookup(32'h0000_0600, draw_gap());
        send_lookup(32'h0000_0800, draw_gap());
        wait_drained();

        // Grow to all ways, so the ways outside the shrunk range are compared again.
        set_geometry(4'd1, 4'd8, 4'd8);
        send_lookup(32'h0000_0600, draw_gap());
        send_lookup(32'h0000_0400, draw_gap());
        wait_drained();

        // A ways code of zero clamps to a single way.
        set_geometry(4'd1, 4'd8, 4'd0);
        send_lookup(32'h0000_0400, draw_gap());

        // Random phases, each under a freshly drawn geometry and address pool.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            set_geometry(pick_reg(1, 10), pick_reg(2, 8), pick_reg(1, MAX_WAYS));
            for (int k = 0; k < TAG_POOL_SIZE; k++) begin
                tag_pool[k] = $urandom;
            end
            for (int k = 0; k < SET_POOL_SIZE; k++) begin
                set_pool[k] = $urandom & ((32'd1 << geo_ib) - 32'd1);
            end
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == ITEMS_PER_PHASE / 2 && $urandom_range(0, 1) == 1) begin
                    wait_drained();
                end
                send_lookup(shaped_address(), calm ? 0 : draw_gap());
            end
        end

        // Drain and give the verdict.
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
